// ===== rtl/stodc_pkg.sv =====
// ----------------------------------------------------------------------------
// Settable time-of-day clock package
// Shared types and constants: item structs, mode and key codes, reset values.
// ----------------------------------------------------------------------------
package stodc_pkg;

  // Clock modes, in the order that key A steps through them.
  typedef enum logic [1:0] {
    MODE_RUN  = 2'd0,
    MODE_MIN  = 2'd1,
    MODE_HOUR = 2'd2
  } mode_e;

  // Key codes as delivered by the edge-detected key input.
  typedef enum logic [1:0] {
    KEY_NONE  = 2'd0,
    KEY_A     = 2'd1,
    KEY_B     = 2'd2,
    KEY_OTHER = 2'd3
  } key_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_TICKS_PER_SECOND = 1'b0,
    CFG_BLINK_TICK       = 1'b1
  } cfg_index_e;

  localparam logic [7:0] ResetTicksPerSecond = 8'd125;
  localparam logic [7:0] ResetBlinkTick      = 8'd62;
  localparam logic [3:0] BlankDigit          = 4'd10;

  // Reset time 08:56:00, held as decimal digits.
  localparam logic [1:0] ResetHourTens  = 2'd0;
  localparam logic [3:0] ResetHourUnits = 4'd8;
  localparam logic [2:0] ResetMinTens   = 3'd5;
  localparam logic [3:0] ResetMinUnits  = 4'd6;

  // One input transfer.
  typedef struct packed {
    logic       tick;
    logic [1:0] key_press;
  } in_item_t;

  // One result transfer.
  typedef struct packed {
    logic [3:0] hours_tens;
    logic [3:0] hours_units;
    logic [2:0] minutes_tens;
    logic [3:0] minutes_units;
    logic [2:0] seconds_tens;
    logic [3:0] seconds_units;
    logic       colon_visible;
    logic [1:0] clock_mode;
  } out_item_t;

endpackage

// ===== rtl/settable_time_of_day_clock.sv =====
// ----------------------------------------------------------------------------
// Settable time-of-day clock
// Hours, minutes and seconds with colon blink and a key-driven set mode.
// ----------------------------------------------------------------------------
// Each result is registered in the output register, or in the skid entry while the output stalls.
// Throughput: one input transfer per cycle while the skid entry is empty; the
// time, mode and key update is a single pass of logic on digit registers, and
// a two-entry output stage lets the input keep flowing while one result waits.
// Reset: asynchronous, active low; time 08:56:00 in run mode, colons shown,
// configuration back to 125 ticks per second and a blink point of 62.
module settable_time_of_day_clock (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  stodc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output stodc_pkg::out_item_t out_data_o
);

  // Configuration registers.
  logic [7:0] tps_q, blink_q;

  // Clock state, time held as decimal digits.
  stodc_pkg::mode_e mode_q, mode_d;
  stodc_pkg::key_e  pend_q, pend_d;
  logic [7:0] tick_q, tick_d;
  logic [2:0] sec_t_q, sec_t_d;
  logic [3:0] sec_u_q, sec_u_d;
  logic [2:0] min_t_q, min_t_d;
  logic [3:0] min_u_q, min_u_d;
  logic [1:0] hr_t_q, hr_t_d;
  logic [3:0] hr_u_q, hr_u_d;
  logic       colon_q, colon_d;

  // Output stage with skid entry.
  logic                 out_valid_q, skid_valid_q;
  stodc_pkg::out_item_t out_q, skid_q, res_d;
  logic                 in_fire, out_fire;

  assign in_fire  = in_valid_i && !skid_valid_q;
  assign out_fire = out_valid_q && !out_stall_i;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q   <= stodc_pkg::ResetTicksPerSecond;
      blink_q <= stodc_pkg::ResetBlinkTick;
    end else if (cfg_we_i) begin
      unique case (stodc_pkg::cfg_index_e'(cfg_index_i))
        stodc_pkg::CFG_TICKS_PER_SECOND: tps_q   <= cfg_data_i;
        stodc_pkg::CFG_BLINK_TICK:       blink_q <= cfg_data_i;
        default:                         tps_q   <= tps_q;
      endcase
    end
  end

  // Next state for one main-loop pass.
  always_comb begin
    logic [7:0] tick_inc;
    logic       sec_max, min_max, hr_max;
    mode_d  = mode_q;
    pend_d  = pend_q;
    tick_d  = tick_q;
    sec_t_d = sec_t_q;
    sec_u_d = sec_u_q;
    min_t_d = min_t_q;
    min_u_d = min_u_q;
    hr_t_d  = hr_t_q;
    hr_u_d  = hr_u_q;
    colon_d = colon_q;
    tick_inc = tick_q + 8'd1;
    sec_max  = (sec_t_q == 3'd5) && (sec_u_q == 4'd9);
    min_max  = (min_t_q == 3'd5) && (min_u_q == 4'd9);
    hr_max   = (hr_t_q == 2'd2) && (hr_u_q == 4'd3);

    // A new key replaces the pending one.
    if (stodc_pkg::key_e'(in_data_i.key_press) != stodc_pkg::KEY_NONE) begin
      pend_d = stodc_pkg::key_e'(in_data_i.key_press);
    end

    unique case (mode_q)
      stodc_pkg::MODE_MIN: begin
        sec_t_d = 3'd0;
        sec_u_d = 4'd0;
        if (pend_d == stodc_pkg::KEY_B) begin
          pend_d = stodc_pkg::KEY_NONE;
          if (min_max) begin
            min_t_d = 3'd0;
            min_u_d = 4'd0;
          end else if (min_u_q == 4'd9) begin
            min_u_d = 4'd0;
            min_t_d = min_t_q + 3'd1;
          end else begin
            min_u_d = min_u_q + 4'd1;
          end
        end else if (pend_d == stodc_pkg::KEY_A) begin
          pend_d = stodc_pkg::KEY_NONE;
          mode_d = stodc_pkg::MODE_HOUR;
        end
      end
      stodc_pkg::MODE_HOUR: begin
        if (pend_d == stodc_pkg::KEY_B) begin
          pend_d = stodc_pkg::KEY_NONE;
          if (hr_max) begin
            hr_t_d = 2'd0;
            hr_u_d = 4'd0;
          end else if (hr_u_q == 4'd9) begin
            hr_u_d = 4'd0;
            hr_t_d = hr_t_q + 2'd1;
          end else begin
            hr_u_d = hr_u_q + 4'd1;
          end
        end else if (pend_d == stodc_pkg::KEY_A) begin
          pend_d = stodc_pkg::KEY_NONE;
          mode_d = stodc_pkg::MODE_RUN;
        end
      end
      default: begin
        // Run mode; the unused code behaves the same.
        mode_d = stodc_pkg::MODE_RUN;
        if (in_data_i.tick) begin
          tick_d = tick_inc;
          if (tick_inc == blink_q) begin
            colon_d = 1'b0;
          end
          if (tick_inc == tps_q) begin
            tick_d  = 8'd0;
            colon_d = 1'b1;
            if (sec_max) begin
              sec_t_d = 3'd0;
              sec_u_d = 4'd0;
              if (min_max) begin
                min_t_d = 3'd0;
                min_u_d = 4'd0;
                if (hr_max) begin
                  hr_t_d = 2'd0;
                  hr_u_d = 4'd0;
                end else if (hr_u_q == 4'd9) begin
                  hr_u_d = 4'd0;
                  hr_t_d = hr_t_q + 2'd1;
                end else begin
                  hr_u_d = hr_u_q + 4'd1;
                end
              end else if (min_u_q == 4'd9) begin
                min_u_d = 4'd0;
                min_t_d = min_t_q + 3'd1;
              end else begin
                min_u_d = min_u_q + 4'd1;
              end
            end else if (sec_u_q == 4'd9) begin
              sec_u_d = 4'd0;
              sec_t_d = sec_t_q + 3'd1;
            end else begin
              sec_u_d = sec_u_q + 4'd1;
            end
          end
        end
        if (pend_d == stodc_pkg::KEY_A) begin
          pend_d  = stodc_pkg::KEY_NONE;
          mode_d  = stodc_pkg::MODE_MIN;
          sec_t_d = 3'd0;
          sec_u_d = 4'd0;
        end
      end
    endcase

    // The colons stay lit while a field is being set.
    if (mode_d != stodc_pkg::MODE_RUN) begin
      colon_d = 1'b1;
    end
  end

  // Result taken from the updated state; a leading zero hour is blanked.
  always_comb begin
    res_d.hours_tens    = (hr_t_d == 2'd0) ? stodc_pkg::BlankDigit : {2'b00, hr_t_d};
    res_d.hours_units   = hr_u_d;
    res_d.minutes_tens  = min_t_d;
    res_d.minutes_units = min_u_d;
    res_d.seconds_tens  = sec_t_d;
    res_d.seconds_units = sec_u_d;
    res_d.colon_visible = colon_d;
    res_d.clock_mode    = mode_d;
  end

  // State registers advance on each input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= stodc_pkg::MODE_RUN;
      pend_q  <= stodc_pkg::KEY_NONE;
      tick_q  <= 8'd0;
      sec_t_q <= 3'd0;
      sec_u_q <= 4'd0;
      min_t_q <= stodc_pkg::ResetMinTens;
      min_u_q <= stodc_pkg::ResetMinUnits;
      hr_t_q  <= stodc_pkg::ResetHourTens;
      hr_u_q  <= stodc_pkg::ResetHourUnits;
      colon_q <= 1'b1;
    end else if (in_fire) begin
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      tick_q  <= tick_d;
      sec_t_q <= sec_t_d;
      sec_u_q <= sec_u_d;
      min_t_q <= min_t_d;
      min_u_q <= min_u_d;
      hr_t_q  <= hr_t_d;
      hr_u_q  <= hr_u_d;
      colon_q <= colon_d;
    end
  end

  // Output register and skid entry control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output and skid payload.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/stodc_checker.sv =====
// ----------------------------------------------------------------------------
// Settable time-of-day clock checker
// Port-level assertions on results and handshake, bound to the top level.
// ----------------------------------------------------------------------------
module stodc_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input stodc_pkg::out_item_t out_data_o
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // A fresh result needs an input transfer in the cycle before.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result appeared without an input transfer");

  // Colons are lit in both set modes.
  a_colon_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.clock_mode != stodc_pkg::MODE_RUN)
    |-> out_data_o.colon_visible)
    else $error("colons blanked while setting");

  // Seconds read zero while minutes are being set.
  a_sec_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.clock_mode == stodc_pkg::MODE_MIN)
    |-> (out_data_o.seconds_tens == 3'd0) && (out_data_o.seconds_units == 4'd0))
    else $error("seconds not cleared in minute set");

endmodule

bind settable_time_of_day_clock stodc_checker u_stodc_checker (.*);
